// File: rtl/sorted_priority_queue_defines.svh
// Assertion macros shared by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTH

// Clocked property on clk, disabled while rst_n is low.
`define SQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge.
`define SQ_ASSERT_NEVER(lbl, expr, msg) \
  `SQ_ASSERT(lbl, !(expr), msg)

`else

`define SQ_ASSERT(lbl, prop, msg)
`define SQ_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// File: rtl/sq_pkg.sv
// Types, constants and helper functions of the sorted priority queue.
`default_nettype none

package sq_pkg;

  // Number of cells in the queue.
  localparam int QUEUE_DEPTH = 16;
  // Fill counter width; it holds zero through QUEUE_DEPTH.
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Operation codes of an input transfer.
  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_REINSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE   = 2'd2;

  // Status codes of a result transfer.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // Input item.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  entry_priority;
    logic [31:0] entry_payload;
  } sq_in_t;

  // Result item.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  head_priority;
    logic [31:0] head_payload;
    logic [4:0]  occupancy;
  } sq_out_t;

  // What every cell does in the current cycle.
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SHIFT
  } sq_cmd_t;

  // Control broadcast from the top level to all cells.
  typedef struct packed {
    sq_cmd_t     cmd;
    logic        reinsert;
    logic        mode;
    logic [7:0]  prio;
    logic [31:0] payload;
  } sq_ctl_t;

  // True when priority a is served before priority b under the given order.
  function automatic logic better(input logic mode, input logic [7:0] a,
                                  input logic [7:0] b);
    better = mode ? (a > b) : (a < b);
  endfunction

endpackage

`default_nettype wire

// File: rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: control, fill count and cell row.
//
//   Channel   Direction  Handshake               Contents
//   in_       input      in_valid / in_ready     sq_in_t: opcode, priority, payload
//   out_      output     out_valid / out_ready   sq_out_t: status, head, occupancy
//   cfg_      input      cfg_valid / cfg_ready   order_mode bit
//
// An accepted item updates the cells at its accepting edge; its result is valid
// from the next cycle, so one item per cycle can be taken while out_ready is high.
// The insert position ripples through the row of cells as a one-bit found chain.
// The result waits in an output register; in_ready stays low while it waits unread.
// Reset empties the queue and selects lowest number first; no clearing pass.
// The configuration port is always ready.
`default_nettype none
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire sq_pkg::sq_in_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output sq_pkg::sq_out_t     out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic           cfg_data
);

  localparam int D = sq_pkg::QUEUE_DEPTH;
  localparam int W = sq_pkg::CNT_W;

  logic                 mode_r;
  logic [W-1:0]         fill_r, fill_nxt;
  logic                 out_valid_r;
  sq_pkg::sq_out_t      out_data_r, out_data_nxt;
  sq_pkg::sq_ctl_t      ctl;
  logic                 in_fire;
  logic                 is_ins;
  logic                 full;
  logic                 empty;
  logic                 head_tie;
  logic [D:0]           found;
  logic [7:0]           slot_prio    [D];
  logic [31:0]          slot_payload [D];

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign full      = (fill_r == W'(D));
  assign empty     = (fill_r == '0);
  assign is_ins    = (in_data.opcode == sq_pkg::OP_INSERT) ||
                     (in_data.opcode == sq_pkg::OP_REINSERT);

  // Broadcast control to the cells.
  always_comb begin
    ctl.reinsert = (in_data.opcode == sq_pkg::OP_REINSERT);
    ctl.mode     = mode_r;
    ctl.prio     = in_data.entry_priority;
    ctl.payload  = in_data.entry_payload;
    if (in_fire && is_ins && !full) begin
      ctl.cmd = sq_pkg::CMD_INSERT;
    end else if (in_fire && (in_data.opcode == sq_pkg::OP_REMOVE) && !empty) begin
      ctl.cmd = sq_pkg::CMD_SHIFT;
    end else begin
      ctl.cmd = sq_pkg::CMD_HOLD;
    end
  end

  // A re-insert equal to the held head lands right after it.
  assign head_tie = !empty && (slot_prio[0] == in_data.entry_priority);

  // Row of cells; cell 0 is the head.
  assign found[0] = 1'b0;
  for (genvar i = 0; i < D; i++) begin : g_cell
    logic [7:0]  lp, rp;
    logic [31:0] ld, rd;
    if (i == 0) begin : g_left_edge
      assign lp = in_data.entry_priority;
      assign ld = in_data.entry_payload;
    end else begin : g_left
      assign lp = slot_prio[i-1];
      assign ld = slot_payload[i-1];
    end
    if (i == D - 1) begin : g_right_edge
      assign rp = slot_prio[i];
      assign rd = slot_payload[i];
    end else begin : g_right
      assign rp = slot_prio[i+1];
      assign rd = slot_payload[i+1];
    end
    sq_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .is_head      ((i == 0)),
      .force_tie    ((i == 1) ? head_tie : 1'b0),
      .occ          (W'(i) < fill_r),
      .found_in     (found[i]),
      .left_prio    (lp),
      .left_payload (ld),
      .right_prio   (rp),
      .right_payload(rd),
      .found_out    (found[i+1]),
      .slot_prio    (slot_prio[i]),
      .slot_payload (slot_payload[i])
    );
  end

  // Fill count and result of the accepted item.
  always_comb begin
    fill_nxt                   = fill_r;
    out_data_nxt.status        = sq_pkg::ST_OK;
    out_data_nxt.head_priority = '0;
    out_data_nxt.head_payload  = '0;
    case (ctl.cmd)
      sq_pkg::CMD_INSERT: fill_nxt = fill_r + W'(1);
      sq_pkg::CMD_SHIFT: begin
        fill_nxt                   = fill_r - W'(1);
        out_data_nxt.head_priority = slot_prio[0];
        out_data_nxt.head_payload  = slot_payload[0];
      end
      default: fill_nxt = fill_r;
    endcase
    if (is_ins && full) begin
      out_data_nxt.status = sq_pkg::ST_OVERFLOW;
    end else if ((in_data.opcode == sq_pkg::OP_REMOVE) && empty) begin
      out_data_nxt.status = sq_pkg::ST_UNDERFLOW;
    end
    out_data_nxt.occupancy = 5'(fill_nxt);
  end

  // Control registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      if (in_fire) begin
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SQ_ASSERT_NEVER(a_fill_bound, fill_r > W'(D), "fill count above queue depth")
  `SQ_ASSERT(a_insert_grows,
             in_fire && is_ins && !full |=> fill_r == $past(fill_r) + W'(1),
             "insert did not grow the queue")
  `SQ_ASSERT(a_overflow_full,
             out_valid && out_data.status == sq_pkg::ST_OVERFLOW |->
               out_data.occupancy == 5'(D),
             "overflow reported while not full")
  `SQ_ASSERT(a_underflow_zero,
             out_valid && out_data.status == sq_pkg::ST_UNDERFLOW |->
               out_data.occupancy == '0 && out_data.head_payload == '0,
             "underflow result not empty")

endmodule

`default_nettype wire

// File: rtl/sq_cell.sv
// One queue slot: holds an entry and shifts, inserts or holds each cycle.
`default_nettype none

module sq_cell (
  input  wire logic            clk,
  input  wire sq_pkg::sq_ctl_t ctl,
  input  wire logic            is_head,
  input  wire logic            force_tie,
  input  wire logic            occ,
  input  wire logic            found_in,
  input  wire logic [7:0]      left_prio,
  input  wire logic [31:0]     left_payload,
  input  wire logic [7:0]      right_prio,
  input  wire logic [31:0]     right_payload,
  output logic                 found_out,
  output logic [7:0]           slot_prio,
  output logic [31:0]          slot_payload
);

  logic [7:0]  slot_prio_r,    slot_prio_nxt;
  logic [31:0] slot_payload_r, slot_payload_nxt;
  logic        hit;
  logic        hit_eff;

  // Position test: an insert goes before the first entry it beats; a
  // re-insert beats the head, or stops at the first entry that does not
  // beat it, and a tie with the head forces the slot right after the head.
  always_comb begin
    if (is_head || !ctl.reinsert) begin
      hit = sq_pkg::better(ctl.mode, ctl.prio, slot_prio_r);
    end else begin
      hit = !sq_pkg::better(ctl.mode, slot_prio_r, ctl.prio) || force_tie;
    end
    // The first empty cell takes the entry when no held entry claims it.
    hit_eff   = !occ || hit;
    found_out = found_in || hit_eff;
  end

  // Next slot contents.
  always_comb begin
    slot_prio_nxt    = slot_prio_r;
    slot_payload_nxt = slot_payload_r;
    case (ctl.cmd)
      sq_pkg::CMD_INSERT: begin
        if (found_in) begin
          slot_prio_nxt    = left_prio;
          slot_payload_nxt = left_payload;
        end else if (hit_eff) begin
          slot_prio_nxt    = ctl.prio;
          slot_payload_nxt = ctl.payload;
        end
      end
      sq_pkg::CMD_SHIFT: begin
        slot_prio_nxt    = right_prio;
        slot_payload_nxt = right_payload;
      end
      default: begin
        slot_prio_nxt    = slot_prio_r;
        slot_payload_nxt = slot_payload_r;
      end
    endcase
  end

  // Slot storage; contents are meaningful only below the fill count.
  always_ff @(posedge clk) begin
    slot_prio_r    <= slot_prio_nxt;
    slot_payload_r <= slot_payload_nxt;
  end

  assign slot_prio    = slot_prio_r;
  assign slot_payload = slot_payload_r;

endmodule

`default_nettype wire
